FILE: hw/rtl/alzd_pkg.sv
// ----------------------------------------------------------------------------
// ADC LZ decompressor package
// Shared constants, status codes and history access types.
// ----------------------------------------------------------------------------
package alzd_pkg;

    // History ring depth in bytes; a power of two from 1024 to 65536.
    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    // The history is stored as rows of four bytes, split over two banks
    // by row parity, so that any four consecutive bytes are one read.
    localparam int ROW_AW     = HIST_AW - 2;
    localparam int BANK_AW    = HIST_AW - 3;
    localparam int BANK_DEPTH = HIST_DEPTH / 8;

    // Decompressed bytes per result; the row layout is built for four.
    localparam int BYTES_PER_RESULT = 4;

    localparam int CNT_W   = 3;
    localparam int TOTAL_W = 25;
    localparam int LEN_W   = 7;
    localparam int DIST_W  = 17;

    localparam logic [TOTAL_W-1:0] LIMIT_RESET = 25'd16777216;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TRUNC    = 2'd1;
    localparam logic [1:0] ST_FAR      = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef logic [7:0] byte_t;
    typedef byte_t [BYTES_PER_RESULT-1:0] group_t;
    typedef byte_t [2*BYTES_PER_RESULT-1:0] window_t;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] pos;
        logic [CNT_W-1:0]   count;
        group_t             bytes;
    } hist_wr_t;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] pos;
    } hist_rd_t;

endpackage

FILE: hw/rtl/alzd_in_if.sv
// ----------------------------------------------------------------------------
// ADC LZ decompressor input channel
// Valid/ready channel carrying one compressed byte per transaction.
// ----------------------------------------------------------------------------
interface alzd_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);

endinterface

FILE: hw/rtl/alzd_out_if.sv
// ----------------------------------------------------------------------------
// ADC LZ decompressor output channel
// Valid/ready channel carrying up to four decompressed bytes per transaction.
// ----------------------------------------------------------------------------
interface alzd_out_if import alzd_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [7:0]         out_byte0;
    logic [7:0]         out_byte1;
    logic [7:0]         out_byte2;
    logic [7:0]         out_byte3;
    logic [CNT_W-1:0]   byte_count;
    logic               run_last;
    logic [1:0]         status;
    logic               stream_done;
    logic [TOTAL_W-1:0] total_out;

    modport source (
        output valid, output out_byte0, output out_byte1, output out_byte2,
        output out_byte3, output byte_count, output run_last, output status,
        output stream_done, output total_out, input ready
    );
    modport sink (
        input valid, input out_byte0, input out_byte1, input out_byte2,
        input out_byte3, input byte_count, input run_last, input status,
        input stream_done, input total_out, output ready
    );

endinterface

FILE: hw/rtl/alzd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port with byte enables, one read port with registered data.
// ----------------------------------------------------------------------------
module alzd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic [WIDTH/8-1:0]       wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < WIDTH / 8; l++)
        begin
            if (wr_en[l])
            begin
                mem[wr_addr][8*l +: 8] <= wr_data[8*l +: 8];
            end
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/alzd_history.sv
// ----------------------------------------------------------------------------
// ADC LZ decompressor history ring
// Two banks of four-byte rows; reads and writes any four consecutive bytes.
// ----------------------------------------------------------------------------
module alzd_history import alzd_pkg::*; (
    input  logic     clk,
    input  hist_wr_t wr,
    input  hist_rd_t rd,
    output group_t   rd_bytes
);

    logic [ROW_AW-1:0]  wrow;
    logic [ROW_AW-1:0]  rrow;
    window_t            wwin;
    logic [7:0]         wmask;
    logic [BANK_AW-1:0] ev_waddr;
    logic [BANK_AW-1:0] od_waddr;
    logic [BANK_AW-1:0] ev_raddr;
    logic [BANK_AW-1:0] od_raddr;
    logic [3:0]         ev_wen;
    logic [3:0]         od_wen;
    logic [31:0]        ev_wdata;
    logic [31:0]        od_wdata;
    logic [31:0]        ev_q;
    logic [31:0]        od_q;
    logic [1:0]         rshift_reg;
    logic               rswap_reg;
    window_t            rwin;

    // Place the write bytes into an eight-byte window starting at the
    // byte offset inside the first row.
    always_comb
    begin
        wwin  = '0;
        wmask = '0;
        for (int i = 0; i < BYTES_PER_RESULT; i++)
        begin
            if (CNT_W'(i) < wr.count)
            begin
                wwin[3'(wr.pos[1:0]) + 3'(i)]  = wr.bytes[i];
                wmask[3'(wr.pos[1:0]) + 3'(i)] = wr.en;
            end
        end
    end

    // A row with odd index lives in the odd bank, so the lower row of the
    // window swaps banks when the first row is odd.
    assign wrow     = wr.pos[HIST_AW-1:2];
    assign ev_waddr = wrow[ROW_AW-1:1] + BANK_AW'(wrow[0]);
    assign od_waddr = wrow[ROW_AW-1:1];
    assign ev_wen   = wrow[0] ? wmask[7:4] : wmask[3:0];
    assign od_wen   = wrow[0] ? wmask[3:0] : wmask[7:4];
    assign ev_wdata = wrow[0] ? wwin[7:4] : wwin[3:0];
    assign od_wdata = wrow[0] ? wwin[3:0] : wwin[7:4];

    assign rrow     = rd.pos[HIST_AW-1:2];
    assign ev_raddr = rrow[ROW_AW-1:1] + BANK_AW'(rrow[0]);
    assign od_raddr = rrow[ROW_AW-1:1];

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rshift_reg <= rd.pos[1:0];
            rswap_reg  <= rrow[0];
        end
    end

    alzd_ram #(
        .WIDTH (32),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk     (clk),
        .wr_en   (ev_wen),
        .wr_addr (ev_waddr),
        .wr_data (ev_wdata),
        .rd_en   (rd.en),
        .rd_addr (ev_raddr),
        .rd_data (ev_q)
    );

    alzd_ram #(
        .WIDTH (32),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk     (clk),
        .wr_en   (od_wen),
        .wr_addr (od_waddr),
        .wr_data (od_wdata),
        .rd_en   (rd.en),
        .rd_addr (od_raddr),
        .rd_data (od_q)
    );

    assign rwin = rswap_reg ? {ev_q, od_q} : {od_q, ev_q};

    always_comb
    begin
        for (int j = 0; j < BYTES_PER_RESULT; j++)
        begin
            rd_bytes[j] = rwin[3'(rshift_reg) + 3'(j)];
        end
    end

endmodule

FILE: hw/rtl/adc_lz_decompressor.sv
// ----------------------------------------------------------------------------
// ADC LZ decompressor
// Streaming decoder for ADC literal, short match and long match tokens.
// ----------------------------------------------------------------------------
// Usage:
// The din channel takes one compressed byte per transaction; end_of_stream
// marks the last byte of a stream. The dout channel returns up to four
// decompressed bytes per transaction with the running total, the status and
// flags for the last result of an input byte and of the stream.
// limit_wr_en/limit_wr_data set the output limit; the user must write it
// only while the block is idle, as the block does not enforce this. A byte
// that yields at most one result is accepted in IDLE, then decoded in DECODE
// and its result loaded into the output register, waiting in EMIT while that
// register is full. A match of L bytes goes on from DECODE to COPY, which
// waits for its first history read and emits up to four bytes per group; the
// history read port delivers four bytes per cycle while the output is free.
// Reset clears the stream state and sets the limit to 16 MiB; the history
// memory is not cleared, since a match can only reach bytes written in the
// current stream. A finished result waits in the output register while the
// next byte is accepted and decoded; if the receiver stalls, the next result
// holds until the output register frees up, and no result is lost.
// ----------------------------------------------------------------------------
module adc_lz_decompressor import alzd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               limit_wr_en,
    input  logic [TOTAL_W-1:0] limit_wr_data,
    alzd_in_if.sink            din,
    alzd_out_if.source         dout
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT,
        S_COPY
    } state_t;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_LIT,
        PH_OFS_LAST,
        PH_OFS_HIGH
    } phase_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [TOTAL_W-1:0] limit_reg, limit_next;
    logic [TOTAL_W-1:0] prod_reg, prod_next;
    logic [LEN_W-1:0]   plen_reg, plen_next;
    logic [7:0]         pofs_reg, pofs_next;
    logic [1:0]         err_reg, err_next;
    logic               full_reg, full_next;
    logic [7:0]         byte_reg, byte_next;
    logic               eos_reg, eos_next;
    logic               emit_lit_reg, emit_lit_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [HIST_AW-1:0] src_reg, src_next;
    group_t             last4_reg, last4_next;

    logic               ov_reg, ov_next;
    group_t             obytes_reg, obytes_next;
    logic [CNT_W-1:0]   ocnt_reg, ocnt_next;
    logic               olast_reg, olast_next;
    logic [1:0]         ostat_reg, ostat_next;
    logic               odone_reg, odone_next;
    logic [TOTAL_W-1:0] otot_reg, otot_next;

    // Decode of the current byte against the stream state.
    phase_t             dec_phase;
    logic [LEN_W-1:0]   dec_plen;
    logic [7:0]         dec_pofs;
    logic [1:0]         dec_err;
    logic               dec_full;
    logic               dec_lit;
    logic               dec_match;
    logic               dec_result;
    logic [DIST_W-1:0]  dec_dist;
    logic [7:0]         lit_len;

    // Match copy group.
    logic [CNT_W-1:0]   copy_cnt;
    logic               copy_last;
    group_t             copy_bytes;
    group_t             rd_bytes;

    logic               slot_free;
    logic               push;
    logic [CNT_W-1:0]   push_cnt;
    group_t             push_bytes;
    logic               clear;
    hist_wr_t           hist_wr;
    hist_rd_t           hist_rd;

    assign din.ready = (state_reg == S_IDLE);
    assign slot_free = !ov_reg || dout.ready;

    // Token decode. Errors and the limit stop all decoding until the end
    // of the stream; a truncated token is flagged when the stream ends
    // with a token still open.
    always_comb
    begin
        dec_phase = phase_reg;
        dec_plen  = plen_reg;
        dec_pofs  = pofs_reg;
        dec_err   = err_reg;
        dec_full  = full_reg;
        dec_lit   = 1'b0;
        dec_match = 1'b0;
        dec_dist  = DIST_W'({pofs_reg, byte_reg}) + DIST_W'(1);
        lit_len   = {1'b0, byte_reg[6:0]} + 8'd1;
        if (err_reg == ST_OK && !full_reg)
        begin
            case (phase_reg)
                PH_CTRL:
                begin
                    if (prod_reg >= limit_reg)
                    begin
                        dec_full = 1'b1;
                    end
                    else if (byte_reg[7])
                    begin
                        if ({1'b0, prod_reg} + (TOTAL_W+1)'(lit_len) > {1'b0, limit_reg})
                        begin
                            dec_err = ST_OVERFLOW;
                        end
                        else
                        begin
                            dec_plen  = byte_reg[6:0];
                            dec_phase = PH_LIT;
                        end
                    end
                    else if (byte_reg[6])
                    begin
                        dec_plen  = LEN_W'(byte_reg[5:0]) + LEN_W'(4);
                        dec_phase = PH_OFS_HIGH;
                    end
                    else
                    begin
                        dec_plen  = LEN_W'(byte_reg[5:2]) + LEN_W'(3);
                        dec_pofs  = {6'd0, byte_reg[1:0]};
                        dec_phase = PH_OFS_LAST;
                    end
                end
                PH_LIT:
                begin
                    dec_lit = 1'b1;
                    if (plen_reg == '0)
                    begin
                        dec_phase = PH_CTRL;
                    end
                    else
                    begin
                        dec_plen = plen_reg - LEN_W'(1);
                    end
                end
                PH_OFS_HIGH:
                begin
                    dec_pofs  = byte_reg;
                    dec_phase = PH_OFS_LAST;
                end
                PH_OFS_LAST:
                begin
                    if (TOTAL_W'(dec_dist) > prod_reg || dec_dist > DIST_W'(HIST_DEPTH))
                    begin
                        dec_err = ST_FAR;
                    end
                    else if ({1'b0, prod_reg} + (TOTAL_W+1)'(plen_reg) > {1'b0, limit_reg})
                    begin
                        dec_err = ST_OVERFLOW;
                    end
                    else
                    begin
                        dec_match = 1'b1;
                    end
                    dec_phase = PH_CTRL;
                end
                default:
                begin
                    dec_phase = PH_CTRL;
                end
            endcase
            if (eos_reg && dec_err == ST_OK && !dec_full && dec_phase != PH_CTRL)
            begin
                dec_err = ST_TRUNC;
            end
        end
        dec_result = dec_lit || eos_reg || (err_reg == ST_OK && dec_err != ST_OK);
    end

    // One copy group. Sources among the last four bytes produced, or in
    // this group itself, are forwarded from the tail register; the memory
    // read for the first group was issued in DECODE, and for every later group
    // in the same cycle as the previous group's write.
    always_comb
    begin
        logic [1:0] k;
        logic [7:0] g;
        copy_cnt  = (rem_reg > LEN_W'(BYTES_PER_RESULT)) ? CNT_W'(BYTES_PER_RESULT)
                                                         : rem_reg[CNT_W-1:0];
        copy_last = (rem_reg <= LEN_W'(BYTES_PER_RESULT));
        for (int i = 0; i < BYTES_PER_RESULT; i++)
        begin
            case (dist_reg[1:0])
                2'd1:    k = 2'd0;
                2'd2:    k = 2'(i) & 2'd1;
                2'd3:    k = (i == 3) ? 2'd0 : 2'(i);
                default: k = 2'd0;
            endcase
            if (dist_reg <= DIST_W'(3))
            begin
                // Short distances repeat a pattern from the tail.
                g = last4_reg[2'(dist_reg[1:0] - k - 2'd1)];
            end
            else if (dist_reg <= DIST_W'(i + 4))
            begin
                g = last4_reg[2'(dist_reg[2:0] - 3'(i) - 3'd1)];
            end
            else
            begin
                g = rd_bytes[i];
            end
            copy_bytes[i] = (CNT_W'(i) < copy_cnt) ? g : 8'd0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        limit_next    = limit_reg;
        prod_next     = prod_reg;
        plen_next     = plen_reg;
        pofs_next     = pofs_reg;
        err_next      = err_reg;
        full_next     = full_reg;
        byte_next     = byte_reg;
        eos_next      = eos_reg;
        emit_lit_next = emit_lit_reg;
        dist_next     = dist_reg;
        rem_next      = rem_reg;
        src_next      = src_reg;
        last4_next    = last4_reg;
        ov_next       = ov_reg && !dout.ready;
        obytes_next   = obytes_reg;
        ocnt_next     = ocnt_reg;
        olast_next    = olast_reg;
        ostat_next    = ostat_reg;
        odone_next    = odone_reg;
        otot_next     = otot_reg;
        push          = 1'b0;
        push_cnt      = '0;
        push_bytes    = '0;
        clear         = 1'b0;
        hist_rd       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (din.valid)
                begin
                    byte_next  = din.data_byte;
                    eos_next   = din.end_of_stream;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                phase_next = dec_phase;
                plen_next  = dec_plen;
                pofs_next  = dec_pofs;
                err_next   = dec_err;
                full_next  = dec_full;
                if (dec_lit)
                begin
                    push          = 1'b1;
                    push_cnt      = CNT_W'(1);
                    push_bytes[0] = byte_reg;
                    prod_next     = prod_reg + TOTAL_W'(1);
                end
                if (dec_match)
                begin
                    hist_rd.en  = 1'b1;
                    hist_rd.pos = prod_reg[HIST_AW-1:0] - dec_dist[HIST_AW-1:0];
                    src_next    = prod_reg[HIST_AW-1:0] - dec_dist[HIST_AW-1:0];
                    dist_next   = dec_dist;
                    rem_next    = plen_reg;
                    state_next  = S_COPY;
                end
                else if (dec_result)
                begin
                    if (slot_free)
                    begin
                        ov_next        = 1'b1;
                        obytes_next    = '0;
                        obytes_next[0] = dec_lit ? byte_reg : 8'd0;
                        ocnt_next      = CNT_W'(dec_lit);
                        olast_next     = 1'b1;
                        ostat_next     = dec_err;
                        odone_next     = eos_reg;
                        otot_next      = prod_reg + TOTAL_W'(dec_lit);
                        clear          = eos_reg;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        emit_lit_next = dec_lit;
                        state_next    = S_EMIT;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next        = 1'b1;
                    obytes_next    = '0;
                    obytes_next[0] = emit_lit_reg ? byte_reg : 8'd0;
                    ocnt_next      = CNT_W'(emit_lit_reg);
                    olast_next     = 1'b1;
                    ostat_next     = err_reg;
                    odone_next     = eos_reg;
                    otot_next      = prod_reg;
                    clear          = eos_reg;
                    state_next     = S_IDLE;
                end
            end
            S_COPY:
            begin
                if (slot_free)
                begin
                    push        = 1'b1;
                    push_cnt    = copy_cnt;
                    push_bytes  = copy_bytes;
                    prod_next   = prod_reg + TOTAL_W'(copy_cnt);
                    rem_next    = rem_reg - LEN_W'(copy_cnt);
                    ov_next     = 1'b1;
                    obytes_next = copy_bytes;
                    ocnt_next   = copy_cnt;
                    olast_next  = copy_last;
                    ostat_next  = err_reg;
                    odone_next  = copy_last && eos_reg;
                    otot_next   = prod_reg + TOTAL_W'(copy_cnt);
                    if (copy_last)
                    begin
                        clear      = eos_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        hist_rd.en  = 1'b1;
                        hist_rd.pos = src_reg + HIST_AW'(BYTES_PER_RESULT);
                        src_next    = src_reg + HIST_AW'(BYTES_PER_RESULT);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Keep the last four bytes produced, most recent first.
        if (push)
        begin
            for (int j = 0; j < BYTES_PER_RESULT; j++)
            begin
                if (CNT_W'(j) < push_cnt)
                begin
                    last4_next[j] = push_bytes[2'(push_cnt - CNT_W'(j) - CNT_W'(1))];
                end
                else
                begin
                    last4_next[j] = last4_reg[2'(CNT_W'(j) - push_cnt)];
                end
            end
        end

        // The stream state returns to its reset values with the final result.
        if (clear)
        begin
            prod_next  = '0;
            phase_next = PH_CTRL;
            plen_next  = '0;
            pofs_next  = '0;
            err_next   = ST_OK;
            full_next  = 1'b0;
        end

        if (limit_wr_en)
        begin
            limit_next = limit_wr_data;
        end
    end

    assign hist_wr.en    = push;
    assign hist_wr.pos   = prod_reg[HIST_AW-1:0];
    assign hist_wr.count = push_cnt;
    assign hist_wr.bytes = push_bytes;

    alzd_history u_history (
        .clk      (clk),
        .wr       (hist_wr),
        .rd       (hist_rd),
        .rd_bytes (rd_bytes)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_CTRL;
            limit_reg    <= LIMIT_RESET;
            prod_reg     <= '0;
            plen_reg     <= '0;
            pofs_reg     <= '0;
            err_reg      <= ST_OK;
            full_reg     <= 1'b0;
            byte_reg     <= '0;
            eos_reg      <= 1'b0;
            emit_lit_reg <= 1'b0;
            dist_reg     <= '0;
            rem_reg      <= '0;
            src_reg      <= '0;
            last4_reg    <= '0;
            ov_reg       <= 1'b0;
            obytes_reg   <= '0;
            ocnt_reg     <= '0;
            olast_reg    <= 1'b0;
            ostat_reg    <= ST_OK;
            odone_reg    <= 1'b0;
            otot_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            limit_reg    <= limit_next;
            prod_reg     <= prod_next;
            plen_reg     <= plen_next;
            pofs_reg     <= pofs_next;
            err_reg      <= err_next;
            full_reg     <= full_next;
            byte_reg     <= byte_next;
            eos_reg      <= eos_next;
            emit_lit_reg <= emit_lit_next;
            dist_reg     <= dist_next;
            rem_reg      <= rem_next;
            src_reg      <= src_next;
            last4_reg    <= last4_next;
            ov_reg       <= ov_next;
            obytes_reg   <= obytes_next;
            ocnt_reg     <= ocnt_next;
            olast_reg    <= olast_next;
            ostat_reg    <= ostat_next;
            odone_reg    <= odone_next;
            otot_reg     <= otot_next;
        end
    end

    assign dout.valid       = ov_reg;
    assign dout.out_byte0   = obytes_reg[0];
    assign dout.out_byte1   = obytes_reg[1];
    assign dout.out_byte2   = obytes_reg[2];
    assign dout.out_byte3   = obytes_reg[3];
    assign dout.byte_count  = ocnt_reg;
    assign dout.run_last    = olast_reg;
    assign dout.status      = ostat_reg;
    assign dout.stream_done = odone_reg;
    assign dout.total_out   = otot_reg;

`ifndef SYNTH
    // A copy in progress always has bytes left and a nonzero distance.
    a_copy_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY |-> rem_reg != '0 && dist_reg != '0)
        else $error("copy state with no bytes left or zero distance");

    // A result never carries more bytes than one transaction holds.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> ocnt_reg <= CNT_W'(BYTES_PER_RESULT))
        else $error("byte count above group size");

    // The final result of a stream is also the last result of its byte.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && odone_reg |-> olast_reg)
        else $error("stream done without run last");

    // Starting a copy enters COPY with the produced count unchanged; the groups are produced there.
    a_copy_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECODE && dec_match |=> state_reg == S_COPY && prod_reg == $past(prod_reg))
        else $error("copy entry disturbed the produced count");
`endif

endmodule
